/* hw/rtl/sigt_pkg.sv */
// Shared types, codes and constants of the sorted id/gain table.
// No dependencies; every other file of the block but sigt_ram imports this package.
package sigt_pkg;

   localparam int DEF_TABLE_DEPTH = 16;

   localparam int ID_W        = 8;
   localparam int GAIN_W      = 32;
   localparam int ENTRY_W     = ID_W + GAIN_W;
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
   localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
   localparam logic [OP_W-1:0] OP_READ   = 3'd4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   typedef enum logic [2:0] {
      IDX_KEEP,
      IDX_CLEAR,
      IDX_INC,
      IDX_DEC,
      IDX_LOAD_COUNT
   } idx_op_type;

   typedef enum logic [1:0] {
      CNT_KEEP,
      CNT_CLEAR,
      CNT_INC,
      CNT_DEC
   } count_op_type;

   typedef enum logic [1:0] {
      WR_SHIFT,
      WR_NEW,
      WR_GAIN
   } wr_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                load_req;
      idx_op_type          idx_op;
      logic                pos_save;
      logic                mem_rd;
      logic                mem_wr;
      logic                addr_back;
      wr_sel_type          wr_sel;
      count_op_type        count_op;
      logic                finish;
      logic [STATUS_W-1:0] status;
      logic                give_gain;
   } sigt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            at_end;
      logic            at_pos;
      logic            full;
      logic            hit;
      logic            above;
   } sigt_stat_type;

endpackage

/* hw/rtl/sigt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sigt_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/sigt_ctrl.sv */
// Controller state machine of the sorted id/gain table: search, shift and finish sequencing.
// Depends on sigt_pkg.
module sigt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  sigt_pkg::sigt_stat_type stat,
   output sigt_pkg::sigt_cmd_type  cmd
);
   import sigt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CHK,
      S_DECIDE,
      S_ADD_RD,
      S_ADD_WR,
      S_REM_RD,
      S_REM_WR
   } state_type;

   state_type           state_ff, state_in;
   logic                found_ff, found_in;
   logic                busy_ff, busy_in;
   logic                done;
   logic [STATUS_W-1:0] code;
   logic                op_known;

   assign op_known = (stat.op == OP_ADD) || (stat.op == OP_REMOVE) ||
                     (stat.op == OP_UPDATE) || (stat.op == OP_READ);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      found_in = found_ff;
      busy_in  = busy_ff;
      done     = 1'b0;
      code     = ST_DONE;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               cmd.idx_op   = IDX_CLEAR;
               found_in     = 1'b0;
               busy_in      = 1'b1;
               state_in     = S_SRCH_RD;
            end
         end
         S_SRCH_RD: begin
            if (!op_known) begin
               cmd.count_op = (stat.op == OP_CLEAR) ? CNT_CLEAR : CNT_KEEP;
               done         = 1'b1;
            end else if (stat.at_end) begin
               state_in = S_DECIDE;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = S_SRCH_CHK;
            end
         end
         S_SRCH_CHK: begin
            if (stat.hit) begin
               found_in = 1'b1;
               state_in = S_DECIDE;
            end else if (stat.above) begin
               state_in = S_DECIDE;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_SRCH_RD;
            end
         end
         S_DECIDE: begin
            case (stat.op)
               OP_ADD: begin
                  if (found_ff) begin
                     done = 1'b1;
                     code = ST_PRESENT;
                  end else if (stat.full) begin
                     done = 1'b1;
                     code = ST_FULL;
                  end else begin
                     cmd.pos_save = 1'b1;
                     cmd.idx_op   = IDX_LOAD_COUNT;
                     state_in     = S_ADD_RD;
                  end
               end
               OP_REMOVE: begin
                  if (!found_ff) begin
                     done = 1'b1;
                     code = ST_NOT_FOUND;
                  end else begin
                     cmd.pos_save = 1'b1;
                     cmd.idx_op   = IDX_INC;
                     state_in     = S_REM_RD;
                  end
               end
               OP_UPDATE: begin
                  done = 1'b1;
                  if (!found_ff) begin
                     code = ST_NOT_FOUND;
                  end else begin
                     cmd.mem_wr = 1'b1;
                     cmd.wr_sel = WR_GAIN;
                  end
               end
               OP_READ: begin
                  done = 1'b1;
                  if (!found_ff) begin
                     code = ST_NOT_FOUND;
                  end else begin
                     cmd.give_gain = 1'b1;
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end
         S_ADD_RD: begin
            if (stat.at_pos) begin
               cmd.mem_wr   = 1'b1;
               cmd.wr_sel   = WR_NEW;
               cmd.count_op = CNT_INC;
               done         = 1'b1;
            end else begin
               cmd.mem_rd    = 1'b1;
               cmd.addr_back = 1'b1;
               state_in      = S_ADD_WR;
            end
         end
         S_ADD_WR: begin
            cmd.mem_wr = 1'b1;
            cmd.wr_sel = WR_SHIFT;
            cmd.idx_op = IDX_DEC;
            state_in   = S_ADD_RD;
         end
         S_REM_RD: begin
            if (stat.at_end) begin
               cmd.count_op = CNT_DEC;
               done         = 1'b1;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = S_REM_WR;
            end
         end
         S_REM_WR: begin
            cmd.mem_wr    = 1'b1;
            cmd.wr_sel    = WR_SHIFT;
            cmd.addr_back = 1'b1;
            cmd.idx_op    = IDX_INC;
            state_in      = S_REM_RD;
         end
         default: begin
            state_in = S_IDLE;
            busy_in  = 1'b0;
         end
      endcase

      if (done) begin
         cmd.finish = 1'b1;
         cmd.status = code;
         busy_in    = 1'b0;
         state_in   = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         found_ff <= 1'b0;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

/* hw/rtl/sigt_dpath.sv */
// Datapath of the sorted id/gain table: request registers, walk index, entry count,
// table memory and result registers. Depends on sigt_pkg and sigt_ram.
module sigt_dpath #(
   parameter int TABLE_DEPTH = sigt_pkg::DEF_TABLE_DEPTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [sigt_pkg::OP_W-1:0]                req_operation,
   input  logic [sigt_pkg::ID_W-1:0]                req_node_id,
   input  logic signed [sigt_pkg::GAIN_W-1:0]       req_gain_value,
   input  sigt_pkg::sigt_cmd_type                   cmd,
   output sigt_pkg::sigt_stat_type                  stat,
   output logic                                     rsp_strobe,
   output logic [sigt_pkg::STATUS_W-1:0]            rsp_status,
   output logic signed [sigt_pkg::GAIN_W-1:0]       rsp_read_gain,
   output logic [sigt_pkg::COUNT_OUT_W-1:0]         rsp_node_count
);
   import sigt_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic [OP_W-1:0]          op_ff;
   logic [ID_W-1:0]          id_ff;
   logic signed [GAIN_W-1:0] gain_ff;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         pos_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_strobe_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic signed [GAIN_W-1:0] rsp_gain_ff;
   logic [COUNT_OUT_W-1:0]   rsp_count_ff;

   logic [CNT_W-1:0]         addr_full;
   logic [IDX_W-1:0]         addr;
   logic [ENTRY_W-1:0]       wr_data;
   logic [ENTRY_W-1:0]       rd_data;
   logic [ID_W-1:0]          rd_id;
   logic [GAIN_W-1:0]        rd_gain;

   assign rd_id   = rd_data[ENTRY_W-1 -: ID_W];
   assign rd_gain = rd_data[GAIN_W-1:0];

   // A shift moves an entry one place; the back address is the lower neighbor.
   assign addr_full = cmd.addr_back ? (idx_ff - CNT_W'(1)) : idx_ff;
   assign addr      = addr_full[IDX_W-1:0];

   always_comb begin
      case (cmd.wr_sel)
         WR_SHIFT: wr_data = rd_data;
         WR_NEW:   wr_data = {id_ff, GAIN_W'(0)};
         WR_GAIN:  wr_data = {id_ff, gain_ff};
         default:  wr_data = rd_data;
      endcase
   end

   always_comb begin
      case (cmd.idx_op)
         IDX_KEEP:       idx_in = idx_ff;
         IDX_CLEAR:      idx_in = '0;
         IDX_INC:        idx_in = idx_ff + CNT_W'(1);
         IDX_DEC:        idx_in = idx_ff - CNT_W'(1);
         IDX_LOAD_COUNT: idx_in = count_ff;
         default:        idx_in = idx_ff;
      endcase
   end

   always_comb begin
      case (cmd.count_op)
         CNT_KEEP:  count_in = count_ff;
         CNT_CLEAR: count_in = '0;
         CNT_INC:   count_in = count_ff + CNT_W'(1);
         CNT_DEC:   count_in = count_ff - CNT_W'(1);
         default:   count_in = count_ff;
      endcase
   end

   assign stat.op     = op_ff;
   assign stat.at_end = (idx_ff == count_ff);
   assign stat.at_pos = (idx_ff == pos_ff);
   assign stat.full   = (count_ff == CNT_W'(TABLE_DEPTH));
   assign stat.hit    = (rd_id == id_ff);
   assign stat.above  = (rd_id > id_ff);

   sigt_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (cmd.mem_wr),
      .wr_addr(addr),
      .wr_data(wr_data),
      .rd_en  (cmd.mem_rd),
      .rd_addr(addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         pos_ff        <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= cmd.finish;
         if (cmd.pos_save) begin
            pos_ff <= idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_operation;
         id_ff   <= req_node_id;
         gain_ff <= req_gain_value;
      end
      if (cmd.finish) begin
         rsp_status_ff <= cmd.status;
         rsp_gain_ff   <= cmd.give_gain ? signed'(rd_gain) : '0;
         rsp_count_ff  <= COUNT_OUT_W'(count_in);
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_gain  = rsp_gain_ff;
   assign rsp_node_count = rsp_count_ff;

endmodule

/* hw/rtl/sorted_id_gain_table_core.sv */
// Top level of the sorted id/gain table: controller plus datapath.
// Depends on sigt_pkg, sigt_ctrl, sigt_dpath and sigt_ram.

// The block holds up to TABLE_DEPTH distinct 8-bit node ids in ascending order, each
// with a signed Q16.16 gain, and runs one operation per transaction: clear, add (new
// entries start with a gain of zero), remove, update gain, or read gain. A transaction
// is accepted on a rising edge with start high and busy low; busy then stays high until
// the operation is finished, and exactly one result follows as a one-cycle pulse on
// rsp_strobe with status, read gain and the entry count after the operation. The
// receiver cannot stall, so results must be taken in the cycle they appear; a new
// transaction may be started in that same cycle. Timing is set by the single table
// memory, which does one read or one write per cycle with a registered read. The search
// reads and checks each entry in turn, stopping at the first id not below the requested
// one or when it runs past the last held entry; a decide step then sets the outcome.
// An add then moves each later entry up by a read and a write and writes the new
// entry, and a remove moves each later entry down by a read and a write. The
// result appears in the cycle after the operation ends, the same cycle in which busy
// falls. Clear and unused operation codes finish in the first search state, before any
// entry is read. The longest transactions are a lookup of an absent id in a full table
// or an add or remove that touches every entry. Unused codes change nothing and report
// done with a zero gain.
module sorted_id_gain_table_core #(
   parameter int TABLE_DEPTH = sigt_pkg::DEF_TABLE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [sigt_pkg::OP_W-1:0]          req_operation,
   input  logic [sigt_pkg::ID_W-1:0]          req_node_id,
   input  logic signed [sigt_pkg::GAIN_W-1:0] req_gain_value,
   output logic                               rsp_strobe,
   output logic [sigt_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [sigt_pkg::GAIN_W-1:0] rsp_read_gain,
   output logic [sigt_pkg::COUNT_OUT_W-1:0]   rsp_node_count
);
   import sigt_pkg::*;

   // The controller sequences each transaction; the datapath owns all storage.
   sigt_cmd_type  cmd;
   sigt_stat_type stat;

   sigt_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .stat (stat),
      .cmd  (cmd)
   );

   sigt_dpath #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_operation (req_operation),
      .req_node_id   (req_node_id),
      .req_gain_value(req_gain_value),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_read_gain (rsp_read_gain),
      .rsp_node_count(rsp_node_count)
   );

endmodule

/* hw/rtl/sigt_checker.sv */
// Port-level checks of the sorted id/gain table, bound to the top level.
// Depends on sigt_pkg and sorted_id_gain_table_core.
module sigt_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_strobe,
   input logic [sigt_pkg::STATUS_W-1:0]      rsp_status,
   input logic signed [sigt_pkg::GAIN_W-1:0] rsp_read_gain
);
   import sigt_pkg::*;

   // An accepted transaction makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted transaction");

   // A result follows the end of a busy period and never comes while busy.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> (!busy && $past(busy)))
      else $error("result strobe outside the end of a transaction");

   // Two results are never shown in adjacent cycles.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("results in back-to-back cycles");

   // A nonzero gain is only reported by a successful operation.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_strobe && (rsp_read_gain != 0)) |-> (rsp_status == ST_DONE))
      else $error("nonzero gain with a failing status");

endmodule

bind sorted_id_gain_table_core sigt_checker u_sigt_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_strobe   (rsp_strobe),
   .rsp_status   (rsp_status),
   .rsp_read_gain(rsp_read_gain)
);
